// ===== src/vrc_pkg.sv =====
package vrc_pkg;

    // Field widths
    localparam int BYTE_W   = 8;
    localparam int POS_W    = 5;
    localparam int SUM_W    = 16;
    localparam int STATUS_W = 2;
    localparam int WORD_W   = 32;
    localparam int CFG_IDX_W = 2;
    localparam int OUT_TDATA_W = 24;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_SUM_FAIL   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_MAGIC_FAIL = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_FORMAT_FAIL = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FORMAT_VERSION = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHECKSUM_ALGO  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CODE_START     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CODE_SIZE      = 2'd3;

    // Configuration reset values
    localparam logic [BYTE_W-1:0] FORMAT_VERSION_RST = 8'h01;
    localparam logic [BYTE_W-1:0] CHECKSUM_ALGO_RST  = 8'h01;
    localparam logic [WORD_W-1:0] CODE_START_RST     = 32'h0800_0000;
    localparam logic [WORD_W-1:0] CODE_SIZE_RST      = 32'h0004_0000;

    // Record layout
    localparam logic [POS_W-1:0] POS_FORMAT     = 5'd4;
    localparam logic [POS_W-1:0] POS_ALGO       = 5'd13;
    localparam logic [POS_W-1:0] POS_START_0    = 5'd14;
    localparam logic [POS_W-1:0] POS_START_1    = 5'd15;
    localparam logic [POS_W-1:0] POS_START_2    = 5'd16;
    localparam logic [POS_W-1:0] POS_START_3    = 5'd17;
    localparam logic [POS_W-1:0] POS_SIZE_0     = 5'd18;
    localparam logic [POS_W-1:0] POS_SIZE_1     = 5'd19;
    localparam logic [POS_W-1:0] POS_SIZE_2     = 5'd20;
    localparam logic [POS_W-1:0] POS_SIZE_3     = 5'd21;
    localparam logic [POS_W-1:0] POS_SUM_HIGH   = 5'd30;
    localparam logic [POS_W-1:0] POS_LAST       = 5'd31;
    localparam logic [POS_W-1:0] SUM_BYTES      = 5'd30;
    localparam logic [POS_W-1:0] MAGIC_BYTES    = 5'd4;

    // Magic bytes at the head of the record
    localparam logic [BYTE_W-1:0] MAGIC_0 = 8'h53;  // 'S'
    localparam logic [BYTE_W-1:0] MAGIC_1 = 8'h57;  // 'W'
    localparam logic [BYTE_W-1:0] MAGIC_2 = 8'h56;  // 'V'
    localparam logic [BYTE_W-1:0] MAGIC_3 = 8'h31;  // '1'

    // Bit positions of the result fields in the output word
    localparam int OUT_STATUS_LSB = 0;
    localparam int OUT_SUM_LSB    = STATUS_W;
    localparam int OUT_PAD_LSB    = STATUS_W + SUM_W;

endpackage

// ===== src/version_record_checker_unit.sv =====
// Channel   | Direction | Word contents (lowest bit up)         | Rate
// s_axis    | in        | [7:0] record_byte                     | one byte per cycle; byte 31 may stall
// m_axis    | out       | [1:0] status, [17:2] computed_sum,    | one word per 32 bytes
//           |           | [23:18] zero                          |
// cfg       | in        | index 0..3, 32-bit data               | one write per cycle
//
// Each byte is checked and summed in the cycle it is accepted; a new byte can be
// taken every cycle unless byte 31 stalls. The status word of a record is registered
// when byte 31 is accepted and appears on m_axis in the following cycle.
// Reset (synchronous, active low) returns the byte position to 0, clears the sum
// and flags, and loads the register reset values.
// While a status word waits on m_axis, bytes 0 to 30 of the next record are still
// accepted; only byte 31 stalls until the waiting word is taken.
module version_record_checker_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input bytes
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] record_byte
    // Status words
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [1:0] status, [17:2] computed_sum, [23:18] zero
    // Configuration writes
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);

    // Configuration registers
    logic [vrc_pkg::BYTE_W-1:0] r_format_version;
    logic [vrc_pkg::BYTE_W-1:0] r_checksum_algo;
    logic [vrc_pkg::WORD_W-1:0] r_code_start;
    logic [vrc_pkg::WORD_W-1:0] r_code_size;

    // Record state
    logic [vrc_pkg::POS_W-1:0]  r_pos;
    logic [vrc_pkg::SUM_W-1:0]  r_sum;
    logic                       r_magic_bad;
    logic                       r_format_bad;
    logic [vrc_pkg::BYTE_W-1:0] r_sum_high;

    // Output register
    logic                                r_out_vld;
    logic [vrc_pkg::OUT_TDATA_W-1:0]     r_out_data;

    logic [vrc_pkg::SUM_W-1:0]    n_sum;
    logic [vrc_pkg::BYTE_W-1:0]   expect_byte;
    logic                         check_format;
    logic [vrc_pkg::BYTE_W-1:0]   magic_byte;
    logic                         magic_hit;
    logic                         format_hit;
    logic [vrc_pkg::SUM_W-1:0]    tail_sum;
    logic [vrc_pkg::STATUS_W-1:0] n_status;
    logic                         in_acc;
    logic                         is_last;

    // Only the last byte of a record needs room in the output register.
    assign is_last       = (r_pos == vrc_pkg::POS_LAST);
    assign s_axis_tready = !is_last || !r_out_vld || m_axis_tready;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;

    // Running sum covers bytes 0 to 29.
    assign n_sum = (r_pos < vrc_pkg::SUM_BYTES) ? r_sum + {8'd0, s_axis_tdata} : r_sum;

    // Magic byte expected at the current position.
    always_comb begin
        unique case (r_pos[1:0])
            2'd0:    magic_byte = vrc_pkg::MAGIC_0;
            2'd1:    magic_byte = vrc_pkg::MAGIC_1;
            2'd2:    magic_byte = vrc_pkg::MAGIC_2;
            default: magic_byte = vrc_pkg::MAGIC_3;
        endcase
    end
    assign magic_hit = (r_pos < vrc_pkg::MAGIC_BYTES) && (s_axis_tdata != magic_byte);

    // Register byte expected at the current position; the code start and size
    // words are stored big-endian.
    always_comb begin
        check_format = 1'b1;
        expect_byte  = '0;
        case (r_pos)
            vrc_pkg::POS_FORMAT:  expect_byte = r_format_version;
            vrc_pkg::POS_ALGO:    expect_byte = r_checksum_algo;
            vrc_pkg::POS_START_0: expect_byte = r_code_start[31:24];
            vrc_pkg::POS_START_1: expect_byte = r_code_start[23:16];
            vrc_pkg::POS_START_2: expect_byte = r_code_start[15:8];
            vrc_pkg::POS_START_3: expect_byte = r_code_start[7:0];
            vrc_pkg::POS_SIZE_0:  expect_byte = r_code_size[31:24];
            vrc_pkg::POS_SIZE_1:  expect_byte = r_code_size[23:16];
            vrc_pkg::POS_SIZE_2:  expect_byte = r_code_size[15:8];
            vrc_pkg::POS_SIZE_3:  expect_byte = r_code_size[7:0];
            default:              check_format = 1'b0;
        endcase
    end
    assign format_hit = check_format && (s_axis_tdata != expect_byte);

    // Status priority: sum, then magic, then format.
    assign tail_sum = {r_sum_high, s_axis_tdata};
    always_comb begin
        if (tail_sum != r_sum) begin
            n_status = vrc_pkg::STATUS_SUM_FAIL;
        end else if (r_magic_bad) begin
            n_status = vrc_pkg::STATUS_MAGIC_FAIL;
        end else if (r_format_bad) begin
            n_status = vrc_pkg::STATUS_FORMAT_FAIL;
        end else begin
            n_status = vrc_pkg::STATUS_OK;
        end
    end

    // Configuration write port; every index of the 2-bit field is a register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_format_version <= vrc_pkg::FORMAT_VERSION_RST;
            r_checksum_algo  <= vrc_pkg::CHECKSUM_ALGO_RST;
            r_code_start     <= vrc_pkg::CODE_START_RST;
            r_code_size      <= vrc_pkg::CODE_SIZE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                vrc_pkg::REG_FORMAT_VERSION: r_format_version <= i_cfg_data[7:0];
                vrc_pkg::REG_CHECKSUM_ALGO:  r_checksum_algo  <= i_cfg_data[7:0];
                vrc_pkg::REG_CODE_START:     r_code_start     <= i_cfg_data;
                default:                     r_code_size      <= i_cfg_data;
            endcase
        end
    end

    // Record state update on each accepted byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= '0;
            r_sum        <= '0;
            r_magic_bad  <= 1'b0;
            r_format_bad <= 1'b0;
            r_sum_high   <= '0;
        end else if (in_acc) begin
            r_pos <= r_pos + 5'd1;
            if (is_last) begin
                r_sum        <= '0;
                r_magic_bad  <= 1'b0;
                r_format_bad <= 1'b0;
                r_sum_high   <= '0;
            end else begin
                r_sum        <= n_sum;
                r_magic_bad  <= r_magic_bad || magic_hit;
                r_format_bad <= r_format_bad || format_hit;
                if (r_pos == vrc_pkg::POS_SUM_HIGH) begin
                    r_sum_high <= s_axis_tdata;
                end
            end
        end
    end

    // Output register: loaded by byte 31, emptied when the word is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (in_acc && is_last) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && is_last) begin
            r_out_data <= {6'd0, r_sum, n_status};
        end
    end

endmodule

// ===== src/vrc_checker.sv =====
module vrc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [7:0]  s_axis_tdata,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata
);

    logic in_acc;
    logic out_stall;

    assign in_acc    = s_axis_tvalid && s_axis_tready;
    assign out_stall = m_axis_tvalid && !m_axis_tready;

    // A status word appears only right after a byte was taken.
    a_word_from_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(in_acc))
        else $error("status word appeared without an accepted byte");

    // The padding above the sum is always zero.
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[23:18] == 6'd0))
        else $error("status word padding is not zero");

    // The output is empty in the cycle after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("status word valid after reset");

    // A stalled word holds its valid and contents.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_stall |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled status word changed");

    // A waiting word and a newly accepted byte never lose a word: if the
    // output is stalled, any byte taken is not the end of a record, so the
    // valid stays one without being reloaded from a gap.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_stall && in_acc) |=> m_axis_tvalid)
        else $error("status word lost under stall");

endmodule

bind version_record_checker_unit vrc_checker u_vrc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
